FILE: design/mfb_pkg.sv
// ----------------------------------------------------------------------------
// mfb_pkg
// Shared types and constants for the monochrome framebuffer fill block.
// ----------------------------------------------------------------------------
package mfb_pkg;

   localparam int DEF_ROW_COUNT     = 192;
   localparam int DEF_BYTES_PER_ROW = 32;

   localparam int COORD_W  = 11;   // signed pixel coordinates
   localparam int RADDR_W  = 13;   // read_address field width
   localparam int DATA_W   = 8;    // one framebuffer byte
   localparam int CMD_W    = 2;
   localparam int REQ_TDATA_W = 64;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_POINT = 2'd1,
      CMD_BLOCK = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,    // waiting for a beat
      ST_SWEEP,   // write-only pass over the whole store
      ST_READ,    // rmw: read byte at walker address
      ST_WRITE,   // rmw: write merged byte, step walker
      ST_FETCH,   // read command: issue memory read
      ST_DONE     // hand result to output register
   } state_type;

   // walker control from the sequencer
   typedef struct packed {
      logic load;
      logic advance;
   } walk_ctl_type;

endpackage

FILE: design/mfb_ram.sv
// ----------------------------------------------------------------------------
// mfb_ram
// Single-port framebuffer store, registered read data.
// ----------------------------------------------------------------------------
module mfb_ram
   import mfb_pkg::*;
#(
   parameter int DEPTH  = DEF_ROW_COUNT * DEF_BYTES_PER_ROW,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic [ADDR_W-1:0] addr,
   input  logic              wr_en,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   // data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/mfb_walk.sv
// ----------------------------------------------------------------------------
// mfb_walk
// Rectangle walker: steps row by row over the byte columns of a clipped
// rectangle and gives byte address, edge mask and last-byte flag.
// ----------------------------------------------------------------------------
module mfb_walk
   import mfb_pkg::*;
#(
   parameter int ROW_COUNT     = DEF_ROW_COUNT,
   parameter int BYTES_PER_ROW = DEF_BYTES_PER_ROW,
   parameter int ROW_W         = $clog2(ROW_COUNT),
   parameter int COL_W         = $clog2(BYTES_PER_ROW),
   parameter int ADDR_W        = $clog2(ROW_COUNT * BYTES_PER_ROW)
) (
   input  logic              clock,
   input  logic              reset,
   input  walk_ctl_type      ctl,
   input  logic [ROW_W-1:0]  row_first,
   input  logic [ROW_W-1:0]  row_last,
   input  logic [COL_W-1:0]  col_a,
   input  logic [COL_W-1:0]  col_b,
   input  logic [DATA_W-1:0] lmask,
   input  logic [DATA_W-1:0] rmask,
   output logic [ADDR_W-1:0] addr,
   output logic [DATA_W-1:0] mask,
   output logic              last
);

   localparam logic [ROW_W-1:0]  ROW_MAX = ROW_W'(ROW_COUNT - 1);
   localparam logic [COL_W-1:0]  COL_MAX = COL_W'(BYTES_PER_ROW - 1);
   localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(BYTES_PER_ROW);

   logic [ROW_W-1:0]  row_ff,      row_in;
   logic [ROW_W-1:0]  row_last_ff, row_last_in;
   logic [COL_W-1:0]  col_ff,      col_in;
   logic [COL_W-1:0]  col_a_ff,    col_a_in;
   logic [COL_W-1:0]  col_b_ff,    col_b_in;
   logic [DATA_W-1:0] lmask_ff,    lmask_in;
   logic [DATA_W-1:0] rmask_ff,    rmask_in;
   logic [ADDR_W-1:0] base_ff,     base_in;

   logic col_end;
   logic reversed;

   assign col_end  = (col_ff == col_b_ff);
   assign reversed = (col_a_ff > col_b_ff);
   assign last     = col_end && (row_ff == row_last_ff);
   assign addr     = base_ff + ADDR_W'(col_ff);

   always_comb begin
      if (col_a_ff == col_b_ff) begin
         mask = lmask_ff & rmask_ff;
      end else if (col_ff == col_a_ff) begin
         mask = lmask_ff;
      end else if (col_end) begin
         mask = rmask_ff;
      end else begin
         mask = '1;
      end
   end

   always_comb begin
      row_in      = row_ff;
      row_last_in = row_last_ff;
      col_in      = col_ff;
      col_a_in    = col_a_ff;
      col_b_in    = col_b_ff;
      lmask_in    = lmask_ff;
      rmask_in    = rmask_ff;
      base_in     = base_ff;
      if (ctl.load) begin
         row_in      = row_first;
         row_last_in = row_last;
         col_in      = col_a;
         col_a_in    = col_a;
         col_b_in    = col_b;
         lmask_in    = lmask;
         rmask_in    = rmask;
         base_in     = ADDR_W'(row_first * BYTES_PER_ROW);
      end else if (ctl.advance) begin
         if (col_end) begin
            col_in  = col_a_ff;
            row_in  = row_ff + 1'b1;
            base_in = base_ff + ROW_STEP;
         end else if (reversed) begin
            // reversed corners: left edge byte then right edge byte only
            col_in = col_b_ff;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // reset loads a full-screen walk for the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         row_last_ff <= ROW_MAX;
         col_ff      <= '0;
         col_a_ff    <= '0;
         col_b_ff    <= COL_MAX;
         lmask_ff    <= '1;
         rmask_ff    <= '1;
         base_ff     <= '0;
      end else begin
         row_ff      <= row_in;
         row_last_ff <= row_last_in;
         col_ff      <= col_in;
         col_a_ff    <= col_a_in;
         col_b_ff    <= col_b_in;
         lmask_ff    <= lmask_in;
         rmask_ff    <= rmask_in;
         base_ff     <= base_in;
      end
   end

endmodule

FILE: design/mono_framebuffer_fill.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_fill
// One-bit framebuffer (ROW_COUNT rows x BYTES_PER_ROW bytes, MSB = leftmost
// pixel) with clear, point, clipped rectangle fill and byte read commands.
// ----------------------------------------------------------------------------
// Sequence: point and block do a read then a write for each byte touched on
//   the single memory port; a dropped or empty command goes straight to the
//   done state; read goes through the fetch state; clear writes every byte once.
// Throughput: one beat at a time; the next beat is taken once the sequencer
//   is back in idle, even while the previous result waits in the output reg.
// Reset: synchronous; runs a clearing pass over the whole store, one write per
//   byte, during which req_tready stays low.
// ----------------------------------------------------------------------------
module mono_framebuffer_fill
   import mfb_pkg::*;
#(
   parameter int ROW_COUNT     = DEF_ROW_COUNT,
   parameter int BYTES_PER_ROW = DEF_BYTES_PER_ROW
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   // tdata, LSB up: left_x[10:0], top_y[21:11], right_x[32:22],
   //   bottom_y[43:33], ink[44], read_address[57:45], zero fill[63:58]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // tuser: command[1:0]
   input  logic [CMD_W-1:0]       req_tuser,

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // tdata: read_data[7:0]
   output logic [DATA_W-1:0]      rsp_tdata
);

   localparam int STORE_BYTES = ROW_COUNT * BYTES_PER_ROW;
   localparam int SCREEN_W    = 8 * BYTES_PER_ROW;
   localparam int ROW_W       = $clog2(ROW_COUNT);
   localparam int COL_W       = $clog2(BYTES_PER_ROW);
   localparam int XW          = COL_W + 3;   // pixel column on screen
   localparam int ADDR_W      = $clog2(STORE_BYTES);

   localparam logic signed [COORD_W-1:0] X_MAX = COORD_W'(SCREEN_W - 1);
   localparam logic signed [COORD_W-1:0] Y_MAX = COORD_W'(ROW_COUNT - 1);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROW_COUNT - 1);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(BYTES_PER_ROW - 1);

   // ---------------------------------------------------------------- fields
   logic signed [COORD_W-1:0] left_x, top_y, right_x, bottom_y;
   logic                      ink;
   logic [RADDR_W-1:0]        read_address;
   cmd_type                   command;

   assign left_x       = signed'(req_tdata[10:0]);
   assign top_y        = signed'(req_tdata[21:11]);
   assign right_x      = signed'(req_tdata[32:22]);
   assign bottom_y     = signed'(req_tdata[43:33]);
   assign ink          = req_tdata[44];
   assign read_address = req_tdata[57:45];
   assign command      = cmd_type'(req_tuser);

   // -------------------------------------------------------------- clipping
   logic signed [COORD_W-1:0] x1c, x2c, y1c, y2c;
   logic                      point_ok, block_ok;

   assign point_ok = !left_x[COORD_W-1] && !top_y[COORD_W-1] &&
                     (left_x <= X_MAX) && (top_y <= Y_MAX);
   // whole rectangle off screen drops the command
   assign block_ok = !right_x[COORD_W-1] && !bottom_y[COORD_W-1] &&
                     (left_x <= X_MAX) && (top_y <= Y_MAX);

   assign x1c = left_x[COORD_W-1]   ? '0 : left_x;
   assign y1c = top_y[COORD_W-1]    ? '0 : top_y;
   assign x2c = (right_x > X_MAX)   ? X_MAX : right_x;
   assign y2c = (bottom_y > Y_MAX)  ? Y_MAX : bottom_y;

   logic [XW-1:0]     px1, px2;
   logic [ROW_W-1:0]  set_row_first, set_row_last;
   logic [COL_W-1:0]  set_col_a, set_col_b;
   logic [DATA_W-1:0] set_lmask, set_rmask;
   logic              go_walk;

   assign px1 = x1c[XW-1:0];
   assign px2 = x2c[XW-1:0];

   always_comb begin
      // clear: whole screen, full masks
      set_row_first = '0;
      set_row_last  = ROW_LAST;
      set_col_a     = '0;
      set_col_b     = COL_LAST;
      set_lmask     = '1;
      set_rmask     = '1;
      go_walk       = 1'b0;
      case (command)
         CMD_POINT: begin
            set_row_first = y1c[ROW_W-1:0];
            set_row_last  = y1c[ROW_W-1:0];
            set_col_a     = px1[XW-1:3];
            set_col_b     = px1[XW-1:3];
            set_lmask     = 8'h80 >> px1[2:0];
            go_walk       = point_ok;
         end
         CMD_BLOCK: begin
            set_row_first = y1c[ROW_W-1:0];
            set_row_last  = y2c[ROW_W-1:0];
            set_col_a     = px1[XW-1:3];
            set_col_b     = px2[XW-1:3];
            set_lmask     = 8'hFF >> px1[2:0];
            set_rmask     = ~(8'h7F >> px2[2:0]);
            // rows reversed after clamping write nothing
            go_walk       = block_ok && (y1c <= y2c);
         end
         CMD_CLEAR, CMD_READ: begin
            go_walk = 1'b0;
         end
         default: begin
            go_walk = 1'b0;
         end
      endcase
   end

   // ------------------------------------------------------------- registers
   state_type         state_ff, state_in;
   logic              ink_ff, ink_in;
   logic              respond_ff, respond_in;   // low for the reset pass
   logic              rd_cmd_ff, rd_cmd_in;
   logic              rd_zero_ff, rd_zero_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              out_free;

   walk_ctl_type      walk_ctl;
   logic [ADDR_W-1:0] walk_addr;
   logic [DATA_W-1:0] walk_mask;
   logic              walk_last;

   logic [ADDR_W-1:0] ram_addr;
   logic              ram_wr, ram_rd, load_rsp;
   logic [DATA_W-1:0] ram_wdata, ram_rdata;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // ------------------------------------------------------------ next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (command)
                  CMD_CLEAR: state_in = ST_SWEEP;
                  CMD_READ:  state_in = ST_FETCH;
                  CMD_POINT, CMD_BLOCK: begin
                     state_in = go_walk ? ST_READ : ST_DONE;
                  end
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_SWEEP: begin
            if (walk_last) begin
               state_in = respond_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_READ:  state_in = ST_WRITE;
         ST_WRITE: state_in = walk_last ? ST_DONE : ST_READ;
         ST_FETCH: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // --------------------------------------------------------------- outputs
   always_comb begin
      req_tready       = 1'b0;
      walk_ctl.load    = 1'b0;
      walk_ctl.advance = 1'b0;
      ram_wr           = 1'b0;
      ram_rd           = 1'b0;
      load_rsp         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            walk_ctl.load = req_tvalid;
         end
         ST_SWEEP: begin
            ram_wr           = 1'b1;
            walk_ctl.advance = 1'b1;
         end
         ST_READ: begin
            ram_rd = 1'b1;
         end
         ST_WRITE: begin
            ram_wr           = 1'b1;
            walk_ctl.advance = 1'b1;
         end
         ST_FETCH: begin
            ram_rd = !rd_zero_ff;
         end
         ST_DONE: begin
            load_rsp = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // read-modify-write merge; the sweep writes the fill value directly
   always_comb begin
      if (state_ff == ST_SWEEP) begin
         ram_wdata = {DATA_W{ink_ff}};
      end else if (ink_ff) begin
         ram_wdata = ram_rdata | walk_mask;
      end else begin
         ram_wdata = ram_rdata & ~walk_mask;
      end
   end

   assign ram_addr = (state_ff == ST_FETCH) ? rd_addr_ff : walk_addr;

   always_comb begin
      ink_in     = ink_ff;
      respond_in = respond_ff;
      rd_cmd_in  = rd_cmd_ff;
      rd_zero_in = rd_zero_ff;
      rd_addr_in = rd_addr_ff;
      if (accept) begin
         ink_in     = ink;
         respond_in = 1'b1;
         rd_cmd_in  = (command == CMD_READ);
         rd_zero_in = (int'(read_address) >= STORE_BYTES);
         rd_addr_in = read_address[ADDR_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = (rd_cmd_ff && !rd_zero_ff) ? ram_rdata : '0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;   // clearing pass
         ink_ff       <= 1'b0;
         respond_ff   <= 1'b0;
         rd_cmd_ff    <= 1'b0;
         rd_zero_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ink_ff       <= ink_in;
         respond_ff   <= respond_in;
         rd_cmd_ff    <= rd_cmd_in;
         rd_zero_ff   <= rd_zero_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------- instances
   mfb_walk #(
      .ROW_COUNT     (ROW_COUNT),
      .BYTES_PER_ROW (BYTES_PER_ROW),
      .ROW_W         (ROW_W),
      .COL_W         (COL_W),
      .ADDR_W        (ADDR_W)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .ctl       (walk_ctl),
      .row_first (set_row_first),
      .row_last  (set_row_last),
      .col_a     (set_col_a),
      .col_b     (set_col_b),
      .lmask     (set_lmask),
      .rmask     (set_rmask),
      .addr      (walk_addr),
      .mask      (walk_mask),
      .last      (walk_last)
   );

   mfb_ram #(
      .DEPTH  (STORE_BYTES),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .addr    (ram_addr),
      .wr_en   (ram_wr),
      .wr_data (ram_wdata),
      .rd_en   (ram_rd),
      .rd_data (ram_rdata)
   );

   // ------------------------------------------------------------ assertions
   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |-> $past(state_ff) == ST_READ)
      else $error("rmw write without preceding read");

   a_addr_in_range: assert property (@(posedge clock) disable iff (reset)
      (ram_wr || ram_rd) |-> int'(ram_addr) < STORE_BYTES)
      else $error("framebuffer address out of range");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside done state");

endmodule

FILE: verif/mono_framebuffer_fill_tb.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_fill_tb
// Self-checking bench for the framebuffer fill block. Draw and read commands
// go in as stream beats; a shadow framebuffer predicts the byte of each
// result beat, and read beats expose the framebuffer contents.
// ----------------------------------------------------------------------------
module mono_framebuffer_fill_tb;
   import mfb_pkg::*;

   localparam int ROWS        = DEF_ROW_COUNT;
   localparam int BPR         = DEF_BYTES_PER_ROW;
   localparam int FB_BYTES    = ROWS * BPR;
   localparam int SCR_W       = BPR * 8;
   localparam int N_RANDOM    = 1700;
   // worst quiet gap: full-screen fill plus stalls, with margin
   localparam int STALL_LIMIT = 60000;
   localparam int HOLD_CYCLES = 500;   // long receiver hold-off
   localparam int TAIL_CYCLES = 20;
   localparam int IDLE_PCT    = 38;

   typedef struct {
      cmd_type            cmd;
      logic [COORD_W-1:0] lx, ty, rx, by;
      logic               ink;
      logic [RADDR_W-1:0] addr;
      bit                 drain;   // hold this beat until all results are back
   } draw_op_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   wire                    req_tready;
   // tdata, LSB up: left_x, top_y, right_x, bottom_y, ink, read_address, zeros
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   // tuser: command
   logic [CMD_W-1:0]       req_tuser  = '0;
   wire                    rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // tdata: read_data
   wire  [DATA_W-1:0]      rsp_tdata;

   mono_framebuffer_fill dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow framebuffer and command predictor
   // ---------------------------------------------------------------------
   logic [7:0]  shadow_fb [FB_BYTES];
   logic [7:0]  want_bytes [$];    // predicted result bytes, oldest first
   draw_op_type op_queue [$];      // beats not yet offered
   int          fail_count     = 0;
   int          beats_accepted = 0;
   int          results_seen   = 0;

   // set or clear the masked bits of one byte; off-store addresses are ignored
   function automatic void paint_byte(int a, logic [7:0] m, logic ink);
      if (a < 0 || a >= FB_BYTES) return;
      shadow_fb[a] = ink ? (shadow_fb[a] | m) : (shadow_fb[a] & ~m);
   endfunction

   function automatic void paint_rect(int x1, int y1, int x2, int y2, logic ink);
      int ca, cb;
      logic [7:0] lm, rm;
      // wholly off screen: dropped
      if (x2 < 0 || y2 < 0 || x1 > SCR_W - 1 || y1 > ROWS - 1) return;
      if (x1 < 0) x1 = 0;
      if (x2 > SCR_W - 1) x2 = SCR_W - 1;
      if (y1 < 0) y1 = 0;
      if (y2 > ROWS - 1) y2 = ROWS - 1;
      ca = x1 / 8;
      cb = x2 / 8;
      lm = 8'((1 << (8 - (x1 % 8))) - 1);
      rm = 8'(16'hFF80 >> (x2 % 8));
      if (ca == cb) begin
         for (int y = y1; y <= y2; y++) paint_byte(y * BPR + ca, lm & rm, ink);
         return;
      end
      // whole interior bytes; none when the columns are reversed
      for (int c = ca + ((x1 % 8) != 0); c < cb; c++)
         for (int y = y1; y <= y2; y++) paint_byte(y * BPR + c, 8'hFF, ink);
      // edge bytes go in on every row, reversed or not
      for (int y = y1; y <= y2; y++) begin
         paint_byte(y * BPR + ca, lm, ink);
         paint_byte(y * BPR + cb, rm, ink);
      end
   endfunction

   // apply one accepted beat to the shadow and return its result byte
   function automatic logic [7:0] run_command(logic [CMD_W-1:0] code,
                                              logic [REQ_TDATA_W-1:0] d);
      int x1, y1, x2, y2, a;
      logic ink;
      logic [7:0] rd;
      x1  = $signed(d[10:0]);
      y1  = $signed(d[21:11]);
      x2  = $signed(d[32:22]);
      y2  = $signed(d[43:33]);
      ink = d[44];
      a   = d[57:45];
      rd  = '0;
      case (cmd_type'(code))
         CMD_CLEAR: begin
            foreach (shadow_fb[i]) shadow_fb[i] = {8{ink}};
         end
         CMD_POINT: begin
            if (x1 >= 0 && y1 >= 0 && x1 < SCR_W && y1 < ROWS)
               paint_byte(y1 * BPR + x1 / 8, 8'h80 >> (x1 % 8), ink);
         end
         CMD_BLOCK: begin
            paint_rect(x1, y1, x2, y2, ink);
         end
         CMD_READ: begin
            if (a < FB_BYTES) rd = shadow_fb[a];   // beyond the store reads zero
         end
         default: ;
      endcase
      return rd;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: changes at the falling edge, keeps a beat up until taken
   // ---------------------------------------------------------------------
   logic        req_taken   = 1'b0;   // beat accepted at the last rising edge
   bit          beat_loaded = 1'b0;
   draw_op_type cur_op;

   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) beat_loaded = 1'b0;
         if (!beat_loaded && op_queue.size() != 0 &&
             !(op_queue[0].drain && want_bytes.size() != 0) &&
             ((beats_accepted >= 800 && beats_accepted < 1100) ||
              $urandom_range(0, 99) >= IDLE_PCT)) begin
            cur_op = op_queue.pop_front();
            req_tdata <= {{(REQ_TDATA_W - 58){1'b0}}, cur_op.addr, cur_op.ink,
                          cur_op.by, cur_op.rx, cur_op.ty, cur_op.lx};
            req_tuser <= cur_op.cmd;
            beat_loaded = 1'b1;
         end
         req_tvalid <= beat_loaded;
      end
   end

   // ---------------------------------------------------------------------
   // Result receiver: random back-pressure, one long hold-off, one calm stretch
   // ---------------------------------------------------------------------
   int hold_left = 0;
   bit hold_done = 1'b0;

   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && results_seen >= 300) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (results_seen >= 800 && results_seen < 1100) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: check result beats, predict on request beats
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      logic [7:0] exp_byte;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (want_bytes.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result beat, expected none, got %02h",
                        $time, rsp_tdata);
            end else begin
               exp_byte = want_bytes.pop_front();
               if (rsp_tdata !== exp_byte) begin
                  fail_count++;
                  $display("%0t: read_data expected %02h, got %02h",
                           $time, exp_byte, rsp_tdata);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            beats_accepted++;
            want_bytes.push_back(run_command(req_tuser, req_tdata));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: quiet cycles include the clearing pass after reset
   // ---------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   function automatic int rnd11();
      return int'($urandom_range(0, 2047));
   endfunction

   function automatic void add_op(cmd_type c, int x1, int y1, int x2, int y2,
                                  int ink, int a, bit drain);
      draw_op_type op;
      op.cmd   = c;
      op.lx    = COORD_W'(x1);
      op.ty    = COORD_W'(y1);
      op.rx    = COORD_W'(x2);
      op.by    = COORD_W'(y2);
      op.ink   = ink[0];
      op.addr  = RADDR_W'(a);
      op.drain = drain;
      op_queue.push_back(op);
   endfunction

   function automatic int clip(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   initial begin
      int sel, x1, y1, x2, y2, a, hot_addr;
      bit drain;

      foreach (shadow_fb[i]) shadow_fb[i] = '0;   // cleared by reset
      hot_addr = 0;

      // directed: reads of the cleared store at both ends
      add_op(CMD_READ, rnd11(), rnd11(), rnd11(), rnd11(), 1, 0, 0);
      add_op(CMD_READ, rnd11(), rnd11(), rnd11(), rnd11(), 0, FB_BYTES - 1, 0);
      // corner pixels, then points off the left, right and bottom of the screen
      add_op(CMD_POINT, 0, 0, rnd11(), rnd11(), 1, 8191, 0);
      add_op(CMD_POINT, SCR_W - 1, ROWS - 1, rnd11(), rnd11(), 1, 0, 0);
      add_op(CMD_POINT, -1, 5, 0, 0, 1, 0, 0);
      add_op(CMD_POINT, SCR_W, 5, 0, 0, 1, 0, 0);
      add_op(CMD_POINT, 5, ROWS, 0, 0, 1, 0, 0);
      add_op(CMD_POINT, -1024, 1023, 1023, -1024, 1, 0, 0);
      add_op(CMD_READ, 0, 0, 0, 0, 0, 0, 0);
      add_op(CMD_READ, 0, 0, 0, 0, 0, FB_BYTES - 1, 0);
      // blocks wholly off screen: right edge left of screen, top below it
      add_op(CMD_BLOCK, 40, 40, -1, 60, 1, 0, 0);
      add_op(CMD_BLOCK, 0, ROWS, 10, 1023, 1, 0, 0);
      // extreme corners, clamped to the full screen
      add_op(CMD_BLOCK, -1024, -1024, 1023, 1023, 1, 0, 0);
      add_op(CMD_READ, 0, 0, 0, 0, 0, FB_BYTES - 1, 0);
      add_op(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
      // single byte span, then reversed columns within one byte (empty mask)
      add_op(CMD_BLOCK, 3, 2, 5, 2, 1, 0, 0);
      add_op(CMD_READ, 0, 0, 0, 0, 0, 2 * BPR, 0);
      add_op(CMD_BLOCK, 14, 3, 10, 3, 1, 0, 0);
      add_op(CMD_READ, 0, 0, 0, 0, 0, 3 * BPR + 1, 0);
      // reversed columns across bytes: edge masks only
      add_op(CMD_BLOCK, 20, 4, 3, 5, 1, 0, 0);
      add_op(CMD_READ, 0, 0, 0, 0, 0, 4 * BPR + 2, 0);
      // reversed rows: nothing written
      add_op(CMD_BLOCK, 0, 9, 30, 7, 1, 0, 0);
      add_op(CMD_CLEAR, 0, 0, 0, 0, 1, 0, 0);
      add_op(CMD_READ, 0, 0, 0, 0, 0, 8191, 0);   // beyond the store
      add_op(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);

      // random: mostly small draws around a moving spot, reads near it
      for (int n = 0; n < N_RANDOM; n++) begin
         sel   = $urandom_range(0, 999);
         drain = (n % 200 == 199);
         if (sel < 4) begin
            add_op(CMD_CLEAR, rnd11(), rnd11(), rnd11(), rnd11(),
                   $urandom_range(0, 1), $urandom_range(0, 8191), drain);
         end else if (sel < 200) begin
            if ($urandom_range(0, 9) == 0) begin
               x1 = rnd11();
               y1 = rnd11();
            end else begin
               x1 = int'($urandom_range(0, SCR_W + 7)) - 4;
               y1 = int'($urandom_range(0, ROWS + 3)) - 2;
            end
            hot_addr = clip(y1, 0, ROWS - 1) * BPR + clip(x1, 0, SCR_W - 1) / 8;
            add_op(CMD_POINT, x1, y1, rnd11(), rnd11(), $urandom_range(0, 1),
                   $urandom_range(0, 8191), drain);
         end else if (sel < 550) begin
            if ($urandom_range(0, 99) < 3) begin
               x1 = rnd11();
               y1 = rnd11();
               x2 = rnd11();
               y2 = rnd11();
            end else begin
               x1 = int'($urandom_range(0, SCR_W + 15)) - 8;
               x2 = x1 + int'($urandom_range(0, 40)) - 8;
               y1 = int'($urandom_range(0, ROWS + 7)) - 4;
               y2 = y1 + int'($urandom_range(0, 14)) - 3;
            end
            hot_addr = clip(y1, 0, ROWS - 1) * BPR + clip(x1, 0, SCR_W - 1) / 8;
            add_op(CMD_BLOCK, x1, y1, x2, y2, $urandom_range(0, 1),
                   $urandom_range(0, 8191), drain);
         end else begin
            if ($urandom_range(0, 19) == 0) a = $urandom_range(0, 8191);
            else a = clip(hot_addr + int'($urandom_range(0, 80)) - 40, 0, FB_BYTES - 1);
            add_op(CMD_READ, rnd11(), rnd11(), rnd11(), rnd11(),
                   $urandom_range(0, 1), a, drain);
         end
      end

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // drain everything, then let the block settle
      while (op_queue.size() != 0 || req_tvalid || want_bytes.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
